// ===== hdl/assert_macros.svh =====
// Assertion macros for the enumeration sequencer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, gated by the active-low reset
`define USBENUM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("usbenum assertion failed");

// next-cycle implication, gated by the active-low reset
`define USBENUM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("usbenum assertion failed");

`endif

// ===== hdl/usbenum_pkg.sv =====
// Package: types, codes and constants of the enumeration sequencer
package usbenum_pkg;

    localparam int USBENUM_TIMER_BITS = 16;

    localparam logic [15:0] RESET_HOLD_DEFAULT    = 16'd55;
    localparam logic [15:0] REPLY_TIMEOUT_DEFAULT = 16'd100;
    localparam logic [15:0] DEV_CFG_TIMEOUT_DEFAULT = 16'd1000;

    localparam logic [7:0]  DESC_MIN_LEN     = 8'd18;
    localparam logic [7:0]  DESC_TYPE_DEVICE = 8'h01;
    localparam logic [7:0]  MIN_MAX_PACKET   = 8'd8;
    localparam logic [7:0]  SINGLE_CONFIG    = 8'h01;
    localparam logic [15:0] SHORT_READ_LEN   = 16'd8;
    localparam logic [15:0] FULL_DESC_LEN    = 16'd18;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_CONNECT = 1'b1;

    localparam logic [2:0] PORT_RESET_ACTIVE = 3'd0;
    localparam logic [2:0] PORT_ENABLED      = 3'd1;
    localparam logic [2:0] PORT_CONNECTED    = 3'd2;
    localparam logic [2:0] PORT_POWER_DOWN   = 3'd3;

    localparam logic [2:0] CH_DETACHED  = 3'd0;
    localparam logic [2:0] CH_IDLE      = 3'd1;
    localparam logic [2:0] CH_ACTIVE    = 3'd2;
    localparam logic [2:0] CH_READY_IN  = 3'd3;
    localparam logic [2:0] CH_READY_OUT = 3'd4;

    localparam logic [2:0] DEV_NONE        = 3'd0;
    localparam logic [2:0] DEV_CONFIGURING = 3'd1;
    localparam logic [2:0] DEV_ACTIVE      = 3'd2;
    localparam logic [2:0] DEV_ERROR       = 3'd3;
    localparam logic [2:0] DEV_CLOSED      = 3'd4;

    localparam logic [1:0] CFG_IDX_RESET_HOLD    = 2'd0;
    localparam logic [1:0] CFG_IDX_REPLY_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_IDX_DEV_CFG       = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE         = 4'd0,
        ST_RESET        = 4'd1,
        ST_WAIT_ENABLE  = 4'd2,
        ST_GET_MPS      = 4'd3,
        ST_SET_ADDRESS  = 4'd4,
        ST_GET_DEV_DESC = 4'd5,
        ST_GET_CONFIG   = 4'd6,
        ST_DEV_CONFIG   = 4'd7,
        ST_ERROR        = 4'd8
    } state_t;

    typedef enum logic [3:0] {
        STAT_NONE        = 4'd0,
        STAT_READY       = 4'd1,
        STAT_SHORT       = 4'd2,
        STAT_MISMATCH    = 4'd3,
        STAT_MULTICONFIG = 4'd4,
        STAT_TIMEOUT     = 4'd5,
        STAT_CHANNEL     = 4'd6,
        STAT_POWERDOWN   = 4'd7,
        STAT_PORT        = 4'd8,
        STAT_NODEVICE    = 4'd9,
        STAT_CFGERR      = 4'd10,
        STAT_UNEXPECTED  = 4'd11
    } status_t;

    typedef enum logic [1:0] {
        REQ_NONE     = 2'd0,
        REQ_GET_DESC = 2'd1,
        REQ_SET_ADDR = 2'd2,
        REQ_GET_CFG  = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        PRST_NONE    = 2'd0,
        PRST_ASSERT  = 2'd1,
        PRST_RELEASE = 2'd2
    } port_rst_t;

    typedef enum logic [1:0] {
        CHCMD_NONE   = 2'd0,
        CHCMD_ATTACH = 2'd1,
        CHCMD_DETACH = 2'd2
    } ch_cmd_t;

    typedef enum logic [1:0] {
        PW_NONE = 2'd0,
        PW_MPS  = 2'd1,
        PW_ADDR = 2'd2
    } param_wr_t;

    typedef enum logic [1:0] {
        HCMD_NONE     = 2'd0,
        HCMD_INIT     = 2'd1,
        HCMD_FORWARD  = 2'd2,
        HCMD_CFG_ERR  = 2'd3
    } hnd_cmd_t;

    typedef struct packed {
        logic [15:0] reset_hold_ticks;
        logic [15:0] reply_timeout_ticks;
        logic [15:0] device_config_timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic        operation;
        logic [2:0]  port_state;
        logic [2:0]  channel_state;
        logic [15:0] reply_count;
        logic [7:0]  reply_byte0;
        logic [7:0]  reply_byte1;
        logic [7:0]  reply_byte4;
        logic [7:0]  reply_byte7;
        logic [7:0]  reply_byte17;
        logic [15:0] config_total_length;
        logic [6:0]  free_address;
        logic [2:0]  device_state;
    } item_t;

    typedef struct packed {
        req_kind_t   request_kind;
        logic [6:0]  request_value;
        logic [15:0] request_length;
        port_rst_t   port_reset_drive;
        logic        port_disable;
        ch_cmd_t     channel_command;
        param_wr_t   param_write;
        logic [7:0]  param_value;
        hnd_cmd_t    handler_command;
        state_t      enum_state_out;
        status_t     status_code;
    } result_t;

endpackage

// ===== hdl/usbenum_cfg.sv =====
// Configuration register file: reset hold and timeout tick counts
module usbenum_cfg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_addr,
    input  logic [15:0]          cfg_data,
    output usbenum_pkg::cfg_t    cfg
);

    usbenum_pkg::cfg_t cfg_reg;
    usbenum_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                usbenum_pkg::CFG_IDX_RESET_HOLD:    cfg_next.reset_hold_ticks = cfg_data;
                usbenum_pkg::CFG_IDX_REPLY_TIMEOUT: cfg_next.reply_timeout_ticks = cfg_data;
                usbenum_pkg::CFG_IDX_DEV_CFG:
                    cfg_next.device_config_timeout_ticks = cfg_data;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_hold_ticks            <= usbenum_pkg::RESET_HOLD_DEFAULT;
            cfg_reg.reply_timeout_ticks         <= usbenum_pkg::REPLY_TIMEOUT_DEFAULT;
            cfg_reg.device_config_timeout_ticks <= usbenum_pkg::DEV_CFG_TIMEOUT_DEFAULT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/usbenum_core.sv =====
// Combinational step logic: next enumeration state, lease timer and result fields
module usbenum_core #(
    parameter int TIMER_BITS = usbenum_pkg::USBENUM_TIMER_BITS
) (
    input  usbenum_pkg::cfg_t      cfg,
    input  usbenum_pkg::item_t     item,
    input  usbenum_pkg::state_t    state_cur,
    input  logic [TIMER_BITS-1:0]  lease_elapsed,
    input  logic [TIMER_BITS-1:0]  lease_limit,
    input  logic [7:0]             max_packet,
    input  logic [6:0]             address,
    input  logic                   bound,
    output usbenum_pkg::state_t    state_next,
    output logic [TIMER_BITS-1:0]  lease_elapsed_next,
    output logic [TIMER_BITS-1:0]  lease_limit_next,
    output logic [7:0]             max_packet_next,
    output logic [6:0]             address_next,
    output logic                   bound_next,
    output usbenum_pkg::result_t   result
);

    localparam int WW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
    localparam logic [TIMER_BITS-1:0] TMAX = '1;

    function automatic logic [TIMER_BITS-1:0] sat_ticks(input logic [15:0] ticks);
        logic [WW-1:0] wide;
        wide = WW'(ticks);
        return (wide > WW'(TMAX)) ? TMAX : TIMER_BITS'(wide);
    endfunction

    logic                  tick;
    logic [TIMER_BITS-1:0] elapsed_inc;
    logic                  expired;
    logic                  reply_ok;
    logic                  failed;
    usbenum_pkg::status_t  status;

    assign tick        = (item.operation == usbenum_pkg::OP_TICK);
    assign elapsed_inc = (lease_elapsed == TMAX) ? lease_elapsed
                                                 : lease_elapsed + TIMER_BITS'(1);
    assign expired     = (elapsed_inc >= lease_limit);
    assign reply_ok    = tick && !expired && (item.channel_state == usbenum_pkg::CH_IDLE);
    assign failed      = (status != usbenum_pkg::STAT_NONE) &&
                         (status != usbenum_pkg::STAT_READY);

    // next state, status and stored values
    always_comb begin
        state_next         = state_cur;
        status             = usbenum_pkg::STAT_NONE;
        lease_elapsed_next = tick ? elapsed_inc : lease_elapsed;
        lease_limit_next   = lease_limit;
        max_packet_next    = max_packet;
        address_next       = address;
        bound_next         = bound;
        if (!tick) begin
            if (state_cur == usbenum_pkg::ST_IDLE) begin
                lease_elapsed_next = '0;
                lease_limit_next   = sat_ticks(cfg.reset_hold_ticks);
                state_next         = usbenum_pkg::ST_RESET;
            end
        end else begin
            case (state_cur)
                usbenum_pkg::ST_RESET: begin
                    if (item.port_state == usbenum_pkg::PORT_RESET_ACTIVE) begin
                        if (expired) begin
                            state_next = usbenum_pkg::ST_WAIT_ENABLE;
                        end
                    end else begin
                        state_next = usbenum_pkg::ST_IDLE;
                    end
                end
                usbenum_pkg::ST_WAIT_ENABLE: begin
                    if (item.port_state == usbenum_pkg::PORT_ENABLED) begin
                        state_next = usbenum_pkg::ST_GET_MPS;
                    end else if (item.port_state == usbenum_pkg::PORT_POWER_DOWN) begin
                        status = usbenum_pkg::STAT_POWERDOWN;
                    end else if (item.port_state != usbenum_pkg::PORT_CONNECTED) begin
                        status = usbenum_pkg::STAT_PORT;
                    end
                end
                usbenum_pkg::ST_ERROR: begin
                    if (item.channel_state == usbenum_pkg::CH_DETACHED) begin
                        state_next = usbenum_pkg::ST_IDLE;
                    end
                end
                usbenum_pkg::ST_GET_MPS, usbenum_pkg::ST_SET_ADDRESS,
                usbenum_pkg::ST_GET_DEV_DESC, usbenum_pkg::ST_GET_CONFIG,
                usbenum_pkg::ST_DEV_CONFIG: begin
                    if (expired) begin
                        status = usbenum_pkg::STAT_TIMEOUT;
                    end else if (item.channel_state inside {usbenum_pkg::CH_ACTIVE,
                                 usbenum_pkg::CH_READY_IN, usbenum_pkg::CH_READY_OUT}) begin
                        status = usbenum_pkg::STAT_NONE;
                    end else if (item.channel_state != usbenum_pkg::CH_IDLE) begin
                        status = usbenum_pkg::STAT_CHANNEL;
                    end else begin
                        case (state_cur)
                            usbenum_pkg::ST_GET_MPS: begin
                                if (item.reply_byte0 < usbenum_pkg::DESC_MIN_LEN) begin
                                    status = usbenum_pkg::STAT_SHORT;
                                end else if (item.reply_byte1 != usbenum_pkg::DESC_TYPE_DEVICE
                                             || item.reply_byte4 != 8'd0
                                             || item.reply_byte7 < usbenum_pkg::MIN_MAX_PACKET)
                                begin
                                    status = usbenum_pkg::STAT_MISMATCH;
                                end else begin
                                    max_packet_next = item.reply_byte7;
                                    address_next    = item.free_address;
                                    state_next      = usbenum_pkg::ST_SET_ADDRESS;
                                end
                            end
                            usbenum_pkg::ST_SET_ADDRESS: begin
                                state_next = usbenum_pkg::ST_GET_DEV_DESC;
                            end
                            usbenum_pkg::ST_GET_DEV_DESC: begin
                                if (item.reply_byte0 < usbenum_pkg::DESC_MIN_LEN ||
                                    item.reply_byte7 != max_packet) begin
                                    status = usbenum_pkg::STAT_MISMATCH;
                                end else if (item.reply_byte17 != usbenum_pkg::SINGLE_CONFIG)
                                begin
                                    status = usbenum_pkg::STAT_MULTICONFIG;
                                end else begin
                                    state_next = usbenum_pkg::ST_GET_CONFIG;
                                end
                            end
                            usbenum_pkg::ST_GET_CONFIG: begin
                                if (item.reply_count < item.config_total_length) begin
                                    lease_elapsed_next = '0;
                                    lease_limit_next   = sat_ticks(cfg.reply_timeout_ticks);
                                end else if (item.device_state == usbenum_pkg::DEV_NONE) begin
                                    status = usbenum_pkg::STAT_NODEVICE;
                                end else begin
                                    bound_next         = 1'b1;
                                    lease_elapsed_next = '0;
                                    lease_limit_next   =
                                        sat_ticks(cfg.device_config_timeout_ticks);
                                    state_next         = usbenum_pkg::ST_DEV_CONFIG;
                                end
                            end
                            default: begin
                                if (item.device_state == usbenum_pkg::DEV_ACTIVE) begin
                                    bound_next = 1'b0;
                                    status     = usbenum_pkg::STAT_READY;
                                    state_next = usbenum_pkg::ST_IDLE;
                                end else if (item.device_state == usbenum_pkg::DEV_ERROR) begin
                                    status = usbenum_pkg::STAT_CFGERR;
                                end else if (item.device_state == usbenum_pkg::DEV_CLOSED) begin
                                    status = usbenum_pkg::STAT_UNEXPECTED;
                                end
                            end
                        endcase
                    end
                end
                default: state_next = state_cur;
            endcase
            // a new request restarts the reply lease
            if (state_next != state_cur && (state_next == usbenum_pkg::ST_GET_MPS ||
                state_next == usbenum_pkg::ST_SET_ADDRESS ||
                state_next == usbenum_pkg::ST_GET_DEV_DESC ||
                state_next == usbenum_pkg::ST_GET_CONFIG)) begin
                lease_elapsed_next = '0;
                lease_limit_next   = sat_ticks(cfg.reply_timeout_ticks);
            end
            if (status != usbenum_pkg::STAT_NONE && status != usbenum_pkg::STAT_READY) begin
                bound_next = 1'b0;
                state_next = usbenum_pkg::ST_ERROR;
            end
        end
    end

    // result fields
    always_comb begin
        result                 = '0;
        result.enum_state_out  = state_next;
        result.status_code     = status;
        result.port_disable    = failed;
        if (failed && bound) begin
            result.handler_command = usbenum_pkg::HCMD_CFG_ERR;
        end
        if (!tick) begin
            if (state_cur == usbenum_pkg::ST_IDLE) begin
                result.port_reset_drive = usbenum_pkg::PRST_ASSERT;
            end
        end else begin
            case (state_cur)
                usbenum_pkg::ST_RESET: begin
                    if (state_next == usbenum_pkg::ST_WAIT_ENABLE) begin
                        result.port_reset_drive = usbenum_pkg::PRST_RELEASE;
                    end
                end
                usbenum_pkg::ST_WAIT_ENABLE: begin
                    if (state_next == usbenum_pkg::ST_GET_MPS) begin
                        result.channel_command = usbenum_pkg::CHCMD_ATTACH;
                        result.request_kind    = usbenum_pkg::REQ_GET_DESC;
                        result.request_length  = usbenum_pkg::SHORT_READ_LEN;
                    end
                end
                usbenum_pkg::ST_GET_MPS: begin
                    if (state_next == usbenum_pkg::ST_SET_ADDRESS) begin
                        result.param_write   = usbenum_pkg::PW_MPS;
                        result.param_value   = item.reply_byte7;
                        result.request_kind  = usbenum_pkg::REQ_SET_ADDR;
                        result.request_value = item.free_address;
                    end
                end
                usbenum_pkg::ST_SET_ADDRESS: begin
                    if (state_next == usbenum_pkg::ST_GET_DEV_DESC) begin
                        result.param_write    = usbenum_pkg::PW_ADDR;
                        result.param_value    = {1'b0, address};
                        result.request_kind   = usbenum_pkg::REQ_GET_DESC;
                        result.request_length = usbenum_pkg::FULL_DESC_LEN;
                    end
                end
                usbenum_pkg::ST_GET_DEV_DESC: begin
                    if (state_next == usbenum_pkg::ST_GET_CONFIG) begin
                        result.request_kind   = usbenum_pkg::REQ_GET_CFG;
                        result.request_length = usbenum_pkg::SHORT_READ_LEN;
                    end
                end
                usbenum_pkg::ST_GET_CONFIG: begin
                    if (reply_ok && item.reply_count < item.config_total_length) begin
                        result.request_kind   = usbenum_pkg::REQ_GET_CFG;
                        result.request_length = item.config_total_length;
                    end
                    if (state_next == usbenum_pkg::ST_DEV_CONFIG) begin
                        result.handler_command = usbenum_pkg::HCMD_INIT;
                    end
                end
                usbenum_pkg::ST_DEV_CONFIG: begin
                    if (reply_ok && item.device_state == usbenum_pkg::DEV_CONFIGURING) begin
                        result.handler_command = usbenum_pkg::HCMD_FORWARD;
                    end
                    if (state_next == usbenum_pkg::ST_IDLE) begin
                        result.channel_command = usbenum_pkg::CHCMD_DETACH;
                    end
                end
                default: result.port_reset_drive = usbenum_pkg::PRST_NONE;
            endcase
        end
    end

endmodule

// ===== hdl/usb_host_enumeration_sequencer.sv =====
// Top level: USB host enumeration sequencer with stream channels and config port
//
// Input channel s_*: one transaction per event. s_tuser carries the operation
// (tick or port connect), s_tdata the port, channel, reply and handler fields.
// Result channel m_*: exactly one result transaction for every input transaction,
// in order, carrying the commands to issue and the new enumeration state.
// The result register loads at the edge that accepts the input. Throughput is
// one transaction per cycle while s_tready is high; the step logic between the
// input port and the result register is combinational.
// s_tready stays high while the result register is empty or being drained, so a
// stalled receiver holds at most one result and then back-pressures the input.
// Reset (aresetn low, synchronous) returns the sequencer to idle, clears the
// lease timer, stored max packet size, address and handler binding, empties the
// result register and loads the default tick counts (55, 100, 1000).
// cfg_we writes register cfg_addr (0 reset hold, 1 reply timeout, 2 device
// configuration timeout) at the clock edge; write only while idle.
`include "assert_macros.svh"

module usb_host_enumeration_sequencer #(
    parameter int TIMER_BITS = usbenum_pkg::USBENUM_TIMER_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // port_state[2:0] channel_state[5:3] reply_count[21:6] reply_byte0[29:22]
    // reply_byte1[37:30] reply_byte4[45:38] reply_byte7[53:46] reply_byte17[61:54]
    // config_total_length[77:62] free_address[84:78] device_state[87:85]
    input  logic [87:0] s_tdata,
    // operation[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // request_kind[1:0] request_value[8:2] request_length[24:9] port_reset_drive[26:25]
    // port_disable[27] channel_command[29:28] param_write[31:30] param_value[39:32]
    // handler_command[41:40] enum_state_out[45:42] status_code[49:46] zero[55:50]
    output logic [55:0] m_tdata
);

    usbenum_pkg::cfg_t     cfg;
    usbenum_pkg::item_t    item;
    usbenum_pkg::result_t  result;
    usbenum_pkg::result_t  result_reg;

    usbenum_pkg::state_t   state_reg, state_next;
    logic [TIMER_BITS-1:0] lease_elapsed_reg, lease_elapsed_next;
    logic [TIMER_BITS-1:0] lease_limit_reg, lease_limit_next;
    logic [7:0]            max_packet_reg, max_packet_next;
    logic [6:0]            address_reg, address_next;
    logic                  bound_reg, bound_next;
    logic                  out_valid_reg;
    logic                  accept;

    usbenum_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    assign item.operation           = s_tuser;
    assign item.port_state          = s_tdata[2:0];
    assign item.channel_state       = s_tdata[5:3];
    assign item.reply_count         = s_tdata[21:6];
    assign item.reply_byte0         = s_tdata[29:22];
    assign item.reply_byte1         = s_tdata[37:30];
    assign item.reply_byte4         = s_tdata[45:38];
    assign item.reply_byte7         = s_tdata[53:46];
    assign item.reply_byte17        = s_tdata[61:54];
    assign item.config_total_length = s_tdata[77:62];
    assign item.free_address        = s_tdata[84:78];
    assign item.device_state        = s_tdata[87:85];

    usbenum_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .cfg                (cfg),
        .item               (item),
        .state_cur          (state_reg),
        .lease_elapsed      (lease_elapsed_reg),
        .lease_limit        (lease_limit_reg),
        .max_packet         (max_packet_reg),
        .address            (address_reg),
        .bound              (bound_reg),
        .state_next         (state_next),
        .lease_elapsed_next (lease_elapsed_next),
        .lease_limit_next   (lease_limit_next),
        .max_packet_next    (max_packet_next),
        .address_next       (address_next),
        .bound_next         (bound_next),
        .result             (result)
    );

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= usbenum_pkg::ST_IDLE;
            lease_elapsed_reg <= '0;
            lease_limit_reg   <= '0;
            max_packet_reg    <= '0;
            address_reg       <= '0;
            bound_reg         <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (accept) begin
                state_reg         <= state_next;
                lease_elapsed_reg <= lease_elapsed_next;
                lease_limit_reg   <= lease_limit_next;
                max_packet_reg    <= max_packet_next;
                address_reg       <= address_next;
                bound_reg         <= bound_next;
                out_valid_reg     <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg     <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0,
                       result_reg.status_code,
                       result_reg.enum_state_out,
                       result_reg.handler_command,
                       result_reg.param_value,
                       result_reg.param_write,
                       result_reg.channel_command,
                       result_reg.port_disable,
                       result_reg.port_reset_drive,
                       result_reg.request_length,
                       result_reg.request_value,
                       result_reg.request_kind};

    `USBENUM_ASSERT_NXT(a_accept_loads_result, aclk, aresetn, accept, m_tvalid)
    `USBENUM_ASSERT_IMP(a_bound_only_in_dev_config, aclk, aresetn, bound_reg,
                        state_reg == usbenum_pkg::ST_DEV_CONFIG)
    `USBENUM_ASSERT_IMP(a_disable_means_error, aclk, aresetn,
                        m_tvalid && result_reg.port_disable,
                        result_reg.enum_state_out == usbenum_pkg::ST_ERROR)
    `USBENUM_ASSERT_IMP(a_state_tracks_result, aclk, aresetn, m_tvalid,
                        result_reg.enum_state_out == state_reg)

endmodule

// ===== dv/enum_scoreboard_pkg.sv =====
// Scoreboard class: enumeration sequencer prediction and result checking
package enum_scoreboard_pkg;
    import usbenum_pkg::*;

    localparam logic [15:0] TICK_MAX = 16'hFFFF;

    class enum_scoreboard;
        state_t      st;
        logic [15:0] elapsed;
        logic [15:0] limit;
        logic [7:0]  max_packet;
        logic [6:0]  address;
        bit          bound;
        logic [15:0] hold_ticks;
        logic [15:0] reply_ticks;
        logic [15:0] dev_cfg_ticks;
        result_t     pending_results[$];
        int          errors;

        function new();
            st            = ST_IDLE;
            elapsed       = '0;
            limit         = '0;
            max_packet    = '0;
            address       = '0;
            bound         = 1'b0;
            hold_ticks    = RESET_HOLD_DEFAULT;
            reply_ticks   = REPLY_TIMEOUT_DEFAULT;
            dev_cfg_ticks = DEV_CFG_TIMEOUT_DEFAULT;
            errors        = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] v);
            case (idx)
                CFG_IDX_RESET_HOLD:    hold_ticks = v;
                CFG_IDX_REPLY_TIMEOUT: reply_ticks = v;
                CFG_IDX_DEV_CFG:       dev_cfg_ticks = v;
                default: ;
            endcase
        endfunction

        function void start_lease(logic [15:0] ticks);
            elapsed = '0;
            limit   = ticks;
        endfunction

        function void issue(inout result_t r, input req_kind_t kind, input logic [6:0] value,
                            input logic [15:0] len);
            r.request_kind   = kind;
            r.request_value  = value;
            r.request_length = len;
            start_lease(reply_ticks);
        endfunction

        function void fail(inout result_t r, input status_t code);
            if (bound) begin
                r.handler_command = HCMD_CFG_ERR;
                bound = 1'b0;
            end
            r.port_disable = 1'b1;
            r.status_code  = code;
            st = ST_ERROR;
        endfunction

        // expiry wins over the channel state
        function bit reply_ok(inout result_t r, input logic [2:0] ch);
            if (elapsed >= limit) begin
                fail(r, STAT_TIMEOUT);
                return 1'b0;
            end
            case (ch)
                CH_IDLE: return 1'b1;
                CH_ACTIVE, CH_READY_IN, CH_READY_OUT: return 1'b0;
                default: begin
                    fail(r, STAT_CHANNEL);
                    return 1'b0;
                end
            endcase
        endfunction

        function void note_event(item_t it);
            result_t r;
            r = '0;
            if (it.operation == OP_CONNECT) begin
                if (st == ST_IDLE) begin
                    r.port_reset_drive = PRST_ASSERT;
                    start_lease(hold_ticks);
                    st = ST_RESET;
                end
            end else begin
                if (elapsed != TICK_MAX) elapsed++;
                case (st)
                    ST_IDLE: ;
                    ST_RESET: begin
                        if (it.port_state != PORT_RESET_ACTIVE) begin
                            st = ST_IDLE;
                        end else if (elapsed >= limit) begin
                            r.port_reset_drive = PRST_RELEASE;
                            st = ST_WAIT_ENABLE;
                        end
                    end
                    ST_WAIT_ENABLE: begin
                        case (it.port_state)
                            PORT_ENABLED: begin
                                r.channel_command = CHCMD_ATTACH;
                                issue(r, REQ_GET_DESC, '0, SHORT_READ_LEN);
                                st = ST_GET_MPS;
                            end
                            PORT_CONNECTED: ;
                            PORT_POWER_DOWN: fail(r, STAT_POWERDOWN);
                            default: fail(r, STAT_PORT);
                        endcase
                    end
                    ST_ERROR: if (it.channel_state == CH_DETACHED) st = ST_IDLE;
                    default: begin
                        if (reply_ok(r, it.channel_state)) begin
                            case (st)
                                ST_GET_MPS: begin
                                    if (it.reply_byte0 < DESC_MIN_LEN) begin
                                        fail(r, STAT_SHORT);
                                    end else if (it.reply_byte1 != DESC_TYPE_DEVICE ||
                                                 it.reply_byte4 != 8'd0 ||
                                                 it.reply_byte7 < MIN_MAX_PACKET) begin
                                        fail(r, STAT_MISMATCH);
                                    end else begin
                                        r.param_write = PW_MPS;
                                        r.param_value = it.reply_byte7;
                                        max_packet    = it.reply_byte7;
                                        address       = it.free_address;
                                        issue(r, REQ_SET_ADDR, it.free_address, '0);
                                        st = ST_SET_ADDRESS;
                                    end
                                end
                                ST_SET_ADDRESS: begin
                                    r.param_write = PW_ADDR;
                                    r.param_value = {1'b0, address};
                                    issue(r, REQ_GET_DESC, '0, FULL_DESC_LEN);
                                    st = ST_GET_DEV_DESC;
                                end
                                ST_GET_DEV_DESC: begin
                                    if (it.reply_byte0 < DESC_MIN_LEN ||
                                        it.reply_byte7 != max_packet) begin
                                        fail(r, STAT_MISMATCH);
                                    end else if (it.reply_byte17 != SINGLE_CONFIG) begin
                                        fail(r, STAT_MULTICONFIG);
                                    end else begin
                                        issue(r, REQ_GET_CFG, '0, SHORT_READ_LEN);
                                        st = ST_GET_CONFIG;
                                    end
                                end
                                ST_GET_CONFIG: begin
                                    if (it.reply_count < it.config_total_length) begin
                                        issue(r, REQ_GET_CFG, '0, it.config_total_length);
                                    end else if (it.device_state == DEV_NONE) begin
                                        fail(r, STAT_NODEVICE);
                                    end else begin
                                        bound = 1'b1;
                                        start_lease(dev_cfg_ticks);
                                        st = ST_DEV_CONFIG;
                                        r.handler_command = HCMD_INIT;
                                    end
                                end
                                default: begin
                                    case (it.device_state)
                                        DEV_CONFIGURING: r.handler_command = HCMD_FORWARD;
                                        DEV_ACTIVE: begin
                                            bound = 1'b0;
                                            r.channel_command = CHCMD_DETACH;
                                            r.status_code = STAT_READY;
                                            st = ST_IDLE;
                                        end
                                        DEV_ERROR:  fail(r, STAT_CFGERR);
                                        DEV_CLOSED: fail(r, STAT_UNEXPECTED);
                                        default: ;
                                    endcase
                                end
                            endcase
                        end
                    end
                endcase
            end
            r.enum_state_out = st;
            pending_results.push_back(r);
        endfunction

        function void same(string name, logic [15:0] exp_v, logic [15:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [55:0] d);
            result_t e;
            if (pending_results.size() == 0) begin
                $error("result transaction with no pending event");
                errors++;
                return;
            end
            e = pending_results.pop_front();
            same("request_kind", e.request_kind, d[1:0]);
            same("request_value", e.request_value, d[8:2]);
            same("request_length", e.request_length, d[24:9]);
            same("port_reset_drive", e.port_reset_drive, d[26:25]);
            same("port_disable", e.port_disable, d[27]);
            same("channel_command", e.channel_command, d[29:28]);
            same("param_write", e.param_write, d[31:30]);
            same("param_value", e.param_value, d[39:32]);
            same("handler_command", e.handler_command, d[41:40]);
            same("enum_state_out", e.enum_state_out, d[45:42]);
            same("status_code", e.status_code, d[49:46]);
        endfunction
    endclass

endpackage

// ===== dv/tb_top.sv =====
// Testbench top: random and directed enumeration traffic against the sequencer
module tb_top;
    import usbenum_pkg::*;
    import enum_scoreboard_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int LIMIT_CYCLES = 200000;
    localparam int STALL_CYCLES = 60;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    enum_scoreboard sb;
    item_t          offered;
    int             src_idle_pct = 0;
    int             snk_idle_pct = 0;
    int             stall_ask = 0;
    int             stall_seen = 0;
    int             stall_left = 0;

    usb_host_enumeration_sequencer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if (s_tvalid && s_tready) sb.note_event(offered);
        end
    end

    always @(negedge aclk) begin
        if (stall_seen != stall_ask) begin
            stall_seen = stall_ask;
            stall_left = STALL_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic push_event(input item_t it);
        offered = it;
        s_tdata <= {it.device_state, it.free_address, it.config_total_length, it.reply_byte17,
                    it.reply_byte7, it.reply_byte4, it.reply_byte1, it.reply_byte0,
                    it.reply_count, it.channel_state, it.port_state};
        s_tuser  <= it.operation;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic load_regs(input logic [15:0] hold, input logic [15:0] reply,
                             input logic [15:0] devcfg);
        logic [1:0]  idx [3];
        logic [15:0] val [3];
        idx = '{CFG_IDX_RESET_HOLD, CFG_IDX_REPLY_TIMEOUT, CFG_IDX_DEV_CFG};
        val = '{hold, reply, devcfg};
        for (int i = 0; i < 3; i++) begin
            cfg_we   <= 1'b1;
            cfg_addr <= idx[i];
            cfg_data <= val[i];
            sb.write_reg(idx[i], val[i]);
            @(negedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic drain(input int settle);
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (sb.pending_results.size() != 0);
        repeat (settle) @(negedge aclk);
    endtask

    // mostly well-formed steps for the current predicted state, some noise and broken replies
    function automatic item_t make_event();
        item_t       it;
        logic [95:0] bits;
        int          roll;
        int          pick;
        bits = {$urandom, $urandom, $urandom};
        it   = item_t'(bits[88:0]);
        roll = $urandom_range(99);
        pick = $urandom_range(99);
        if (roll < 10) return it;
        it.operation = OP_TICK;
        case (sb.st)
            ST_IDLE:  if (roll < 85) it.operation = OP_CONNECT;
            ST_RESET: if (roll < 95) it.port_state = PORT_RESET_ACTIVE;
            ST_WAIT_ENABLE: begin
                if (pick < 70) it.port_state = PORT_ENABLED;
                else if (pick < 82) it.port_state = PORT_CONNECTED;
                else if (pick < 90) it.port_state = PORT_POWER_DOWN;
                else it.port_state = {1'b1, it.port_state[1:0]};
            end
            ST_ERROR: if (pick < 60) it.channel_state = CH_DETACHED;
            default: begin
                if (roll < 78) it.channel_state = CH_IDLE;
                else if (roll < 94) it.channel_state = (bits[92:91] == 2'd0) ? CH_ACTIVE :
                                                       (bits[92:91] == 2'd1) ? CH_READY_IN :
                                                                               CH_READY_OUT;
                case (sb.st)
                    ST_GET_MPS: begin
                        if (it.reply_byte0 < DESC_MIN_LEN) it.reply_byte0 = DESC_MIN_LEN;
                        it.reply_byte1 = DESC_TYPE_DEVICE;
                        it.reply_byte4 = 8'd0;
                        if (it.reply_byte7 < MIN_MAX_PACKET) it.reply_byte7 = MIN_MAX_PACKET;
                        if (pick >= 85) begin
                            case (pick % 4)
                                0: it.reply_byte0 = it.reply_byte0 % DESC_MIN_LEN;
                                1: it.reply_byte1 = (bits[95:88] == DESC_TYPE_DEVICE) ?
                                                    8'h00 : bits[95:88];
                                2: it.reply_byte4 = (bits[95:88] == 8'd0) ? 8'h01 : bits[95:88];
                                default: it.reply_byte7 = {5'b0, bits[90:88]};
                            endcase
                        end
                    end
                    ST_GET_DEV_DESC: begin
                        if (it.reply_byte0 < DESC_MIN_LEN) it.reply_byte0 = DESC_MIN_LEN;
                        it.reply_byte7  = sb.max_packet;
                        it.reply_byte17 = SINGLE_CONFIG;
                        if (pick >= 85) begin
                            case (pick % 3)
                                0: it.reply_byte0 = it.reply_byte0 % DESC_MIN_LEN;
                                1: it.reply_byte7 = sb.max_packet + 8'd1 + {5'b0, bits[90:88]};
                                default: it.reply_byte17 = (bits[95:88] == SINGLE_CONFIG) ?
                                                           8'h00 : bits[95:88];
                            endcase
                        end
                    end
                    ST_GET_CONFIG: begin
                        if (pick < 10) begin
                            it.reply_count = it.config_total_length;
                        end else if (pick < 55 && it.reply_count < it.config_total_length) begin
                            {it.reply_count, it.config_total_length} =
                                {it.config_total_length, it.reply_count};
                        end
                        if (pick % 10 != 0) it.device_state = {1'b0, bits[89:88]} + 3'd1;
                    end
                    ST_DEV_CONFIG: begin
                        if (pick < 50) it.device_state = DEV_CONFIGURING;
                        else if (pick < 75) it.device_state = DEV_ACTIVE;
                        else if (pick < 83) it.device_state = DEV_ERROR;
                        else if (pick < 90) it.device_state = DEV_CLOSED;
                    end
                    default: ;
                endcase
            end
        endcase
        return it;
    endfunction

    task automatic run_random(input int count);
        item_t it;
        int    n;
        n = 0;
        while (n < count) begin
            while ($urandom_range(99) < src_idle_pct) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
            it = make_event();
            n++;
            push_event(it);
        end
    endtask

    task automatic directed_part();
        item_t d;
        d = '1;
        d.operation = OP_TICK;
        push_event(d);
        d = '0;
        d.operation = OP_CONNECT;
        push_event(d);
        d = '1;
        push_event(d);
        d = '0;
        d.port_state = PORT_RESET_ACTIVE;
        push_event(d);
        d.port_state = PORT_CONNECTED;
        push_event(d);
        d.port_state = PORT_ENABLED;
        push_event(d);
        d.channel_state = CH_ACTIVE;
        push_event(d);
        d.channel_state = CH_IDLE;
        d.reply_byte0   = DESC_MIN_LEN;
        d.reply_byte1   = DESC_TYPE_DEVICE;
        d.reply_byte7   = MIN_MAX_PACKET;
        d.free_address  = '0;
        push_event(d);
        push_event(d);
        d.reply_byte0  = 8'hFF;
        d.reply_byte17 = SINGLE_CONFIG;
        push_event(d);
        d.reply_count         = '0;
        d.config_total_length = 16'hFFFF;
        push_event(d);
        d.reply_count  = 16'hFFFF;
        d.device_state = DEV_CONFIGURING;
        push_event(d);
        push_event(d);
        d.device_state = DEV_NONE;
        push_event(d);
        d.device_state = DEV_ACTIVE;
        push_event(d);
        d = '0;
        d.operation = OP_CONNECT;
        push_event(d);
        d.operation  = OP_TICK;
        d.port_state = 3'd7;
        push_event(d);
        d.operation = OP_CONNECT;
        push_event(d);
        d.operation  = OP_TICK;
        d.port_state = PORT_RESET_ACTIVE;
        push_event(d);
        d.port_state = PORT_POWER_DOWN;
        push_event(d);
        d.channel_state = CH_READY_IN;
        push_event(d);
        d.channel_state = CH_DETACHED;
        push_event(d);
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        load_regs(16'd1, 16'hFFFF, 16'hFFFF);
        directed_part();
        drain(4);

        load_regs(16'd2, 16'd2, 16'd6);
        src_idle_pct = 30;
        snk_idle_pct = 48;
        run_random(350);
        drain(4);

        load_regs(16'hFFFF, 16'd1, 16'd1);
        src_idle_pct = 48;
        snk_idle_pct = 30;
        run_random(100);
        drain(4);

        load_regs(16'd5, REPLY_TIMEOUT_DEFAULT, DEV_CFG_TIMEOUT_DEFAULT);
        run_random(150);
        drain(0);
        run_random(150);
        drain(4);

        load_regs(16'd1, 16'd8, 16'd40);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        stall_ask++;
        run_random(280);
        drain(4);

        if (sb.errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("TEST FAILED");
        $finish;
    end

endmodule
